### rtl/ed3d_pkg.sv
// Package for the 3D Euclidean distance pipeline: sizing constants and
// the sideband struct shared by the top level and the root unit.
// No dependencies.
package ed3d_pkg;

    // Number format
    localparam int COORD_BITS  = 32;       // coordinate width taken from each field
    localparam int COORD_SCALE = 1;        // coordinate units per scene unit
    localparam int FRAC_BITS   = 16;       // fractional bits of the distance

    // Bus field widths
    localparam int IN_W       = 32;
    localparam int IN_DATA_W  = 6 * IN_W;
    localparam int DIST_W     = 49;
    localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

    // Datapath widths
    localparam int DIFF_W = COORD_BITS + 1;               // |b - a|
    localparam int SQ_W   = 2 * DIFF_W;                   // one square, also the sum
    localparam int RW     = COORD_BITS + 1 + FRAC_BITS;   // root width
    localparam int NW     = 2 * RW;                       // radicand width
    localparam int REM_W  = RW + 2;                       // root remainder
    localparam int DIV_W  = $clog2(COORD_SCALE) + 2;      // scale divider remainder

    // Registered stages from input register to output register
    localparam int PIPE_DEPTH = 5 + RW + ((COORD_SCALE > 1) ? RW : 0);
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    typedef struct packed {
        logic vld;
        logic last;
    } t_side;

endpackage

### rtl/ed3d_root.sv
// Pipelined integer square root, one result bit per stage, followed by an
// optional bit-serial pipelined divide by the constant coordinate scale.
// Depends on ed3d_pkg.
module ed3d_root (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  ed3d_pkg::t_side         i_side,
    input  logic [ed3d_pkg::NW-1:0] i_rad,
    output ed3d_pkg::t_side         o_side,
    output logic [ed3d_pkg::RW-1:0] o_root
);
    import ed3d_pkg::*;

    logic [REM_W-1:0] r_rem  [RW];
    logic [RW-1:0]    r_root [RW];
    logic [NW-1:0]    r_rad  [RW];
    logic             r_vld  [RW];
    logic             r_last [RW];

    genvar gi;
    generate
        for (gi = 0; gi < RW; gi++) begin : g_sq
            logic [REM_W-1:0] rem_in;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic [RW-1:0]    root_in;
            logic [NW-1:0]    rad_in;
            logic             vld_in;
            logic             last_in;

            if (gi == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = i_rad;
                assign vld_in  = i_side.vld;
                assign last_in = i_side.last;
            end else begin : g_next
                assign rem_in  = r_rem[gi-1];
                assign root_in = r_root[gi-1];
                assign rad_in  = r_rad[gi-1];
                assign vld_in  = r_vld[gi-1];
                assign last_in = r_last[gi-1];
            end

            // bring down the next two radicand bits, try root bit = 1
            assign rem_sh = {rem_in[REM_W-3:0], rad_in[NW-1 -: 2]};
            assign trial  = {root_in, 2'b01};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gi] <= 1'b0;
                end else if (i_en) begin
                    r_vld[gi] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (rem_sh >= trial) begin
                        r_rem[gi]  <= rem_sh - trial;
                        r_root[gi] <= {root_in[RW-2:0], 1'b1};
                    end else begin
                        r_rem[gi]  <= rem_sh;
                        r_root[gi] <= {root_in[RW-2:0], 1'b0};
                    end
                    r_rad[gi]  <= rad_in << 2;
                    r_last[gi] <= last_in;
                end
            end
        end

        if (COORD_SCALE > 1) begin : g_div
            localparam logic [DIV_W-1:0] SCALE_C = DIV_W'(COORD_SCALE);

            logic [DIV_W-1:0] r_drem [RW];
            logic [RW-1:0]    r_q    [RW];
            logic             r_dvld [RW];
            logic             r_dlast[RW];

            for (gi = 0; gi < RW; gi++) begin : g_step
                logic [DIV_W-1:0] drem_in;
                logic [DIV_W-1:0] drem_sh;
                logic [RW-1:0]    q_in;
                logic             vld_in;
                logic             last_in;

                if (gi == 0) begin : g_first
                    assign drem_in = '0;
                    assign q_in    = r_root[RW-1];
                    assign vld_in  = r_vld[RW-1];
                    assign last_in = r_last[RW-1];
                end else begin : g_next
                    assign drem_in = r_drem[gi-1];
                    assign q_in    = r_q[gi-1];
                    assign vld_in  = r_dvld[gi-1];
                    assign last_in = r_dlast[gi-1];
                end

                // dividend shifts out the top while quotient bits fill in below
                assign drem_sh = {drem_in[DIV_W-2:0], q_in[RW-1]};

                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_dvld[gi] <= 1'b0;
                    end else if (i_en) begin
                        r_dvld[gi] <= vld_in;
                    end
                end

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (drem_sh >= SCALE_C) begin
                            r_drem[gi] <= drem_sh - SCALE_C;
                            r_q[gi]    <= {q_in[RW-2:0], 1'b1};
                        end else begin
                            r_drem[gi] <= drem_sh;
                            r_q[gi]    <= {q_in[RW-2:0], 1'b0};
                        end
                        r_dlast[gi] <= last_in;
                    end
                end
            end

            assign o_root      = r_q[RW-1];
            assign o_side.vld  = r_dvld[RW-1];
            assign o_side.last = r_dlast[RW-1];
        end else begin : g_nodiv
            assign o_root      = r_root[RW-1];
            assign o_side.vld  = r_vld[RW-1];
            assign o_side.last = r_last[RW-1];
        end
    endgenerate

endmodule

### rtl/euclidean_distance_3d.sv
// Top level of the 3D Euclidean distance pipeline.
// Depends on ed3d_pkg and ed3d_root.
//
// Usage:
//   The slave stream carries one point pair per request: six signed
//   coordinates in tdata and the batch-end mark in tlast. The master stream
//   returns floor(|b - a| * 2^FRAC_BITS / COORD_SCALE) in tdata with tlast
//   copied from the request.
//   The pipeline holds PIPE_DEPTH registers: 4 front stages (input register,
//   difference, square, sum), one stage per root bit (49 by default), one
//   stage per quotient bit when the scale is above one, and the output
//   register: 54 with the default sizes. tvalid rises once a pair has
//   passed every stage and reached the output register.
//   Throughput is one pair per clock while the receiver keeps up; the root
//   and divide are fully pipelined, one bit per stage.
//   All stages advance together while the output register is empty or being
//   taken. When the receiver stalls with a result waiting, the pipeline
//   freezes and the input register can still take one more request.
//   Reset (synchronous, active low) clears all valid bits; in-flight pairs
//   are dropped.
module euclidean_distance_3d (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z (32 bits each, signed)
    input  logic [ed3d_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,   // last_pair
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // distance (49 bits, unsigned), zero pad
    output logic [ed3d_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast    // last_result
);
    import ed3d_pkg::*;

    logic en;

    // stage 0: input register
    logic                  r0_vld;
    logic                  r0_last;
    logic [COORD_BITS-1:0] r0_a [3];
    logic [COORD_BITS-1:0] r0_b [3];

    // stage 1: absolute differences
    logic              r1_vld;
    logic              r1_last;
    logic [DIFF_W-1:0] r1_d [3];
    logic [DIFF_W-1:0] diff [3];

    // stage 2: squares
    logic            r2_vld;
    logic            r2_last;
    logic [SQ_W-1:0] r2_sq [3];

    // stage 3: scaled radicand
    logic            r3_vld;
    logic            r3_last;
    logic [NW-1:0]   r3_rad;
    logic [SQ_W-1:0] sum;

    t_side           side_in;
    t_side           side_out;
    logic [RW-1:0]   root;

    logic              r_out_vld;
    logic              r_out_last;
    logic [DIST_W-1:0] r_out_dist;

    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en || !r0_vld;

    // stage 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            for (int k = 0; k < 3; k++) begin
                r0_a[k] <= s_axis_tdata[k*IN_W +: COORD_BITS];
                r0_b[k] <= s_axis_tdata[(k+3)*IN_W +: COORD_BITS];
            end
            r0_last <= s_axis_tlast;
        end
    end

    // stage 1: b - a with one extra bit, then magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {r0_b[k][COORD_BITS-1], r0_b[k]} - {r0_a[k][COORD_BITS-1], r0_a[k]};
        end
    end

    // stages 1..3 and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_out_vld <= side_out.vld;
        end
    end

    assign sum = r2_sq[0] + r2_sq[1] + r2_sq[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k]  <= diff[k][DIFF_W-1] ? (~diff[k] + 1'b1) : diff[k];
                r2_sq[k] <= r1_d[k] * r1_d[k];
            end
            r1_last    <= r0_last;
            r2_last    <= r1_last;
            r3_rad     <= NW'(sum) << (2 * FRAC_BITS);
            r3_last    <= r2_last;
            r_out_dist <= DIST_W'(root);
            r_out_last <= side_out.last;
        end
    end

    assign side_in.vld  = r3_vld;
    assign side_in.last = r3_last;

    ed3d_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (side_in),
        .i_rad   (r3_rad),
        .o_side  (side_out),
        .o_root  (root)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_dist);
    assign m_axis_tlast  = r_out_last;

    // requests accepted but not yet delivered
    always_comb begin
        n_inflight = r_inflight;
        if (s_axis_tvalid && s_axis_tready) begin
            n_inflight = n_inflight + 1'b1;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            n_inflight = n_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_empty_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> !m_axis_tvalid)
        else $error("result presented with nothing in flight");

    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r0_vld && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a stalled output");

    a_stage0_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r0_vld && !en) |=> r0_vld)
        else $error("input register dropped a request during a stall");

    a_root_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(side_out.vld))
        else $error("root pipeline moved during a stall");

endmodule
